// ----- hw/rtl/pss_pkg.sv -----
// Shared types and constants of the priority scheduler.
package pss_pkg;

	localparam int MAX_PROCS = 16;
	localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CNT_W     = $clog2(MAX_PROCS + 1);

	localparam int PRIO_W  = 8;
	localparam int ARR_W   = 16;
	localparam int BURST_W = 16;
	localparam int ID_W    = 5;
	localparam int TIME_W  = 21;
	localparam int SUM_W   = 25;

	localparam int IN_W    = 40;
	localparam int RES_W   = ID_W + 3 * TIME_W + 2 * SUM_W;
	localparam int OUT_W   = ((RES_W + 7) / 8) * 8;

	typedef struct packed {
		logic [BURST_W-1:0] burst;
		logic [ARR_W-1:0]   arrive;
		logic [PRIO_W-1:0]  prio;
	} rec_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		logic             clear;
		logic             wipe;
		logic             mark;
		logic             vld;
		logic [IDX_W-1:0] idx;
	} sel_ctl_t;

	typedef struct packed {
		logic               found;
		logic [IDX_W-1:0]   best_idx;
		logic [ARR_W-1:0]   best_arrive;
		logic [BURST_W-1:0] best_burst;
		logic [ARR_W-1:0]   min_arrive;
	} sel_stat_t;

endpackage

// ----- hw/rtl/pss_table.sv -----
// Process record memory: one write port, one registered read port.
module pss_table
	import pss_pkg::*;
(
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  rec_t             wdata,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr,
	output rec_t             rdata
);

	rec_t mem_q [MAX_PROCS];
	rec_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/pss_select.sv -----
// Sequential pick unit: one record per cycle against the running best, plus completion flags.
module pss_select
	import pss_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  sel_ctl_t          ctl,
	input  rec_t              rec,
	input  logic [TIME_W-1:0] clock_now,
	output sel_stat_t         stat
);

	logic [MAX_PROCS-1:0] done_q;
	logic                 found_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [PRIO_W-1:0]    best_prio_q;
	logic [ARR_W-1:0]     best_arr_q;
	logic [BURST_W-1:0]   best_burst_q;
	logic [ARR_W-1:0]     min_arr_q;

	logic pend;
	logic elig;
	logic better;
	logic take;
	logic lower;

	always_comb begin
		pend   = !done_q[ctl.idx];
		elig   = pend && (TIME_W'(rec.arrive) <= clock_now);
		better = (rec.prio < best_prio_q) ||
			((rec.prio == best_prio_q) && (rec.arrive < best_arr_q));
		take   = ctl.vld && elig && (!found_q || better);
		lower  = ctl.vld && pend && (rec.arrive < min_arr_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= '0;
			found_q <= 1'b0;
		end else begin
			if (ctl.wipe) begin
				done_q <= '0;
			end else if (ctl.mark) begin
				done_q[best_idx_q] <= 1'b1;
			end
			if (ctl.clear) begin
				found_q <= 1'b0;
			end else if (take) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			min_arr_q <= '1;
		end else if (lower) begin
			min_arr_q <= rec.arrive;
		end
		if (take) begin
			best_idx_q   <= ctl.idx;
			best_prio_q  <= rec.prio;
			best_arr_q   <= rec.arrive;
			best_burst_q <= rec.burst;
		end
	end

	always_comb begin
		stat.found       = found_q;
		stat.best_idx    = best_idx_q;
		stat.best_arrive = best_arr_q;
		stat.best_burst  = best_burst_q;
		stat.min_arrive  = min_arr_q;
	end

	a_best_open: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> !done_q[best_idx_q])
		else $error("chosen process already completed");

	a_best_arrived: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (TIME_W'(best_arr_q) <= clock_now))
		else $error("chosen process has not arrived");

endmodule

// ----- hw/rtl/nonpreemptive_priority_scheduler_unit.sv -----
// Top level of the non-preemptive priority scheduler.
//
// Slave stream: one process record per beat (priority, arrival, burst), tlast
// closes the set. Records load at one per cycle; records beyond the table
// capacity are dropped, but their tlast still starts the schedule.
// Master stream: one result per loaded process in completion order (id,
// finish, turnaround, wait), totals and tlast on the final beat.
// Each pick scans the record table one entry per cycle through a single
// compare unit, and scans it again when the clock must jump across an idle
// gap to the earliest pending arrival. s_tready stays low from the tlast beat
// until the final result has entered the output register.
// Reset empties the table and raises s_tready. A result waits in the output
// register while m_tready is low; the next pick finishes its scan and holds
// until that register frees up.
module nonpreemptive_priority_scheduler_unit
	import pss_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // prio_value, arrive_at, run_length
	input  logic             s_tlast,  // last_record
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,  // proc_id, finish_at, turnaround, wait_ticks,
	                                   // sum_wait, sum_turnaround
	output logic             m_tlast   // last_result
);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  scan_q;
	logic [CNT_W-1:0]  round_q;
	logic              vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [TIME_W-1:0] clock_q;
	logic [SUM_W-1:0]  sum_w_q;
	logic [SUM_W-1:0]  sum_t_q;
	logic              m_tvalid_q;
	logic              m_tlast_q;
	logic [RES_W-1:0]  res_q;

	rec_t      wrec;
	rec_t      rrec;
	sel_ctl_t  ctl;
	sel_stat_t stat;

	logic              in_acc;
	logic              room;
	logic              tbl_we;
	logic              rd_en;
	logic              scan_done;
	logic              out_free;
	logic              emit;
	logic              jump;
	logic              final_pick;
	logic [IDX_W:0]    id_ext;
	logic [TIME_W-1:0] fin;
	logic [TIME_W-1:0] wt;
	logic [TIME_W-1:0] tat;
	logic [SUM_W-1:0]  sum_w_n;
	logic [SUM_W-1:0]  sum_t_n;

	assign wrec.prio   = s_tdata[PRIO_W-1:0];
	assign wrec.arrive = s_tdata[PRIO_W+ARR_W-1:PRIO_W];
	assign wrec.burst  = s_tdata[PRIO_W+ARR_W+BURST_W-1:PRIO_W+ARR_W];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_acc && s_tlast) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (jump) begin
					state_d = ST_SCAN;
				end else if (emit) begin
					state_d = final_pick ? ST_LOAD : ST_SCAN;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_comb begin
		s_tready   = (state_q == ST_LOAD);
		in_acc     = s_tvalid && s_tready;
		room       = (cnt_q < CNT_W'(MAX_PROCS));
		tbl_we     = in_acc && room;
		rd_en      = (state_q == ST_SCAN) && (scan_q != cnt_q);
		scan_done  = (state_q == ST_SCAN) && (scan_q == cnt_q) && !vld_s1;
		out_free   = !m_tvalid_q || m_tready;
		emit       = (state_q == ST_DECIDE) && stat.found && out_free;
		jump       = (state_q == ST_DECIDE) && !stat.found;
		final_pick = (CNT_W'(round_q + 1'b1) == cnt_q);
		ctl.wipe   = in_acc && s_tlast;
		ctl.clear  = ctl.wipe || jump || emit;
		ctl.mark   = emit;
		ctl.vld    = vld_s1;
		ctl.idx    = idx_s1;
	end

	always_comb begin
		id_ext  = {1'b0, stat.best_idx} + (IDX_W+1)'(1);
		fin     = clock_q + TIME_W'(stat.best_burst);
		wt      = clock_q - TIME_W'(stat.best_arrive);
		tat     = fin - TIME_W'(stat.best_arrive);
		sum_w_n = sum_w_q + SUM_W'(wt);
		sum_t_n = sum_t_q + SUM_W'(tat);
	end

	pss_table u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata (wrec),
		.re    (rd_en),
		.raddr (scan_q[IDX_W-1:0]),
		.rdata (rrec)
	);

	pss_select u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.rec       (rrec),
		.clock_now (clock_q),
		.stat      (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			cnt_q      <= '0;
			scan_q     <= '0;
			round_q    <= '0;
			vld_s1     <= 1'b0;
			clock_q    <= '0;
			sum_w_q    <= '0;
			sum_t_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_en;
			if (tbl_we) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end else if (emit && final_pick) begin
				cnt_q <= '0;
			end
			if (ctl.clear) begin
				scan_q <= '0;
			end else if (rd_en) begin
				scan_q <= CNT_W'(scan_q + 1'b1);
			end
			if (ctl.wipe) begin
				round_q <= '0;
				clock_q <= '0;
				sum_w_q <= '0;
				sum_t_q <= '0;
			end else if (jump) begin
				clock_q <= TIME_W'(stat.min_arrive);
			end else if (emit) begin
				round_q <= CNT_W'(round_q + 1'b1);
				clock_q <= fin;
				sum_w_q <= sum_w_n;
				sum_t_q <= sum_t_n;
			end
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_q[IDX_W-1:0];
		if (emit) begin
			m_tlast_q <= final_pick;
			res_q     <= {final_pick ? sum_t_n : '0, final_pick ? sum_w_n : '0,
				wt, tat, fin, ID_W'(id_ext)};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = m_tlast_q;
	assign m_tdata  = OUT_W'(res_q);

	a_set_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("input taken after set was closed");

	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> (round_q < cnt_q))
		else $error("more picks than loaded processes");

	a_jump_forward: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE && !stat.found) |-> (TIME_W'(stat.min_arrive) > clock_q))
		else $error("idle jump does not advance the clock");

	a_final_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && final_pick) |=> (m_tvalid && m_tlast && cnt_q == '0))
		else $error("final result not flagged");

endmodule
